// ----- src/v3alu_pkg.sv -----
`timescale 1ns / 1ps
package v3alu_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_NORM  = 4'd7,
        OP_NORMZ = 4'd8,
        OP_NONE  = 4'd15
    } t_op;

    typedef logic signed [DATA_WIDTH-1:0] t_fix;

    typedef struct packed {
        logic [3:0] op;
        t_fix       a_x;
        t_fix       a_y;
        t_fix       a_z;
        t_fix       b_x;
        t_fix       b_y;
        t_fix       b_z;
        t_fix       scale_value;
    } t_in_word;

    typedef struct packed {
        t_op        op;
        t_fix [2:0] a;
        t_fix [2:0] b;
        t_fix       s;
    } t_cmd;

    typedef struct packed {
        t_fix r_x;
        t_fix r_y;
        t_fix r_z;
        logic div_zero;
        logic overflowed;
    } t_out_word;

endpackage

// ----- src/v3alu_fifo.sv -----
`timescale 1ns / 1ps
module v3alu_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = v3alu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output T     o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/v3alu_front.sv -----
`timescale 1ns / 1ps
module v3alu_front (
    input  logic                 i_push,
    input  logic                 i_full,
    input  v3alu_pkg::t_in_word  i_word,
    output logic                 o_push,
    output v3alu_pkg::t_cmd      o_cmd
);

    always_comb begin
        o_push     = i_push && !i_full;
        o_cmd.a[0] = i_word.a_x;
        o_cmd.a[1] = i_word.a_y;
        o_cmd.a[2] = i_word.a_z;
        o_cmd.b[0] = i_word.b_x;
        o_cmd.b[1] = i_word.b_y;
        o_cmd.b[2] = i_word.b_z;
        o_cmd.s    = i_word.scale_value;
        // Codes above the last operation produce an all-zero word.
        if (i_word.op <= 4'(v3alu_pkg::OP_NORMZ)) begin
            o_cmd.op = v3alu_pkg::t_op'(i_word.op);
        end else begin
            o_cmd.op = v3alu_pkg::OP_NONE;
        end
    end

endmodule

// ----- src/v3alu_back.sv -----
`timescale 1ns / 1ps
module v3alu_back #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  v3alu_pkg::t_cmd       i_cmd,
    output logic                  o_valid,
    output v3alu_pkg::t_out_word  o_word
);
    localparam int W  = v3alu_pkg::DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int W1 = W + 1;
    localparam int PW = 2 * W;
    localparam int SW = PW + 2;
    localparam int NB = W + F + 1;
    localparam int CW = (SW > NB + 1) ? SW : NB + 1;
    localparam logic [CW-1:0] HALF = {{(CW-1){1'b0}}, 1'b1} << (F - 1);

    typedef logic signed [W-1:0]  t_val;
    typedef logic signed [PW-1:0] t_prod;

    typedef struct packed {
        v3alu_pkg::t_op op;
        t_val [2:0]     r;
        logic           ovf;
        t_val [2:0]     a;
        t_val           s;
    } t_base;

    typedef struct packed {
        t_base          b;
        logic [PW-1:0]  x;
        logic [W:0]     rem;
        logic [W-1:0]   root;
    } t_sq;

    typedef struct packed {
        v3alu_pkg::t_op     op;
        t_val [2:0]         r;
        logic               ovf;
        logic               dz;
        logic [2:0]         neg;
        logic [2:0][NB-1:0] n;
        logic [2:0][W:0]    rem;
        logic [2:0][NB-1:0] q;
        logic [W:0]         d;
    } t_dv;

    // Returns {saturated, value}.
    function automatic logic [W:0] sat(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        hi = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return {1'b1, hi[W-1:0]};
        end else if (v < lo) begin
            return {1'b1, lo[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    // Stage A: operand register.
    logic            r_av;
    v3alu_pkg::t_cmd r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (i_en) begin
            r_av <= i_valid;
        end
        if (i_en) begin
            r_a <= i_cmd;
        end
    end

    // Stage B: six multipliers, plus the add, subtract and negate results.
    t_val       mx [6];
    t_val       my [6];
    t_base      b_nxt;
    logic [W:0] b_sat;
    logic       r_bv;
    t_base      r_b;
    t_prod      r_p [6];

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            mx[k] = '0;
            my[k] = '0;
        end
        unique case (r_a.op)
            v3alu_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    mx[i] = r_a.a[i];
                    my[i] = r_a.s;
                end
            end
            v3alu_pkg::OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    mx[i] = r_a.a[i];
                    my[i] = r_a.b[i];
                end
            end
            v3alu_pkg::OP_NORM, v3alu_pkg::OP_NORMZ: begin
                for (int i = 0; i < 3; i++) begin
                    mx[i] = r_a.a[i];
                    my[i] = r_a.a[i];
                end
            end
            v3alu_pkg::OP_CROSS: begin
                mx[0] = r_a.a[1]; my[0] = r_a.b[2];
                mx[3] = r_a.a[2]; my[3] = r_a.b[1];
                mx[1] = r_a.a[2]; my[1] = r_a.b[0];
                mx[4] = r_a.a[0]; my[4] = r_a.b[2];
                mx[2] = r_a.a[0]; my[2] = r_a.b[1];
                mx[5] = r_a.a[1]; my[5] = r_a.b[0];
            end
            default: ;
        endcase
    end

    always_comb begin
        b_nxt.op  = r_a.op;
        b_nxt.a   = r_a.a;
        b_nxt.s   = r_a.s;
        b_nxt.r   = '0;
        b_nxt.ovf = 1'b0;
        b_sat     = '0;
        for (int i = 0; i < 3; i++) begin
            unique case (r_a.op)
                v3alu_pkg::OP_ADD: b_sat = sat(CW'($signed(r_a.a[i])) + CW'($signed(r_a.b[i])));
                v3alu_pkg::OP_SUB: b_sat = sat(CW'($signed(r_a.a[i])) - CW'($signed(r_a.b[i])));
                v3alu_pkg::OP_NEG: b_sat = sat(-CW'($signed(r_a.a[i])));
                default:           b_sat = '0;
            endcase
            b_nxt.r[i] = b_sat[W-1:0];
            b_nxt.ovf  = b_nxt.ovf | b_sat[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (i_en) begin
            r_bv <= r_av;
        end
        if (i_en) begin
            r_b <= b_nxt;
            for (int k = 0; k < 6; k++) begin
                r_p[k] <= mx[k] * my[k];
            end
        end
    end

    // Stage C: rounding of product sums, and the sum of squares for the norm.
    t_sq        c_nxt;
    logic [W:0] c_sc [3];
    logic [W:0] c_cr [3];
    logic [W:0] c_dt;
    t_sq        r_sq  [0:W];
    logic       r_sqv [0:W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_sc[i] = sat((CW'(r_p[i]) + $signed(HALF)) >>> F);
            c_cr[i] = sat((CW'(r_p[i]) - CW'(r_p[i+3]) + $signed(HALF)) >>> F);
        end
        c_dt = sat((CW'(r_p[0]) + CW'(r_p[1]) + CW'(r_p[2]) + $signed(HALF)) >>> F);
        c_nxt.b    = r_b;
        c_nxt.x    = r_p[0] + r_p[1] + r_p[2];
        c_nxt.rem  = '0;
        c_nxt.root = '0;
        unique case (r_b.op)
            v3alu_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    c_nxt.b.r[i] = c_sc[i][W-1:0];
                end
                c_nxt.b.ovf = c_sc[0][W] | c_sc[1][W] | c_sc[2][W];
            end
            v3alu_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    c_nxt.b.r[i] = c_cr[i][W-1:0];
                end
                c_nxt.b.ovf = c_cr[0][W] | c_cr[1][W] | c_cr[2][W];
            end
            v3alu_pkg::OP_DOT: begin
                c_nxt.b.r[0] = c_dt[W-1:0];
                c_nxt.b.ovf  = c_dt[W];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv[0] <= 1'b0;
        end else if (i_en) begin
            r_sqv[0] <= r_bv;
        end
        if (i_en) begin
            r_sq[0] <= c_nxt;
        end
    end

    // Square root: one result bit per stage, two radicand bits shifted in.
    for (genvar k = 1; k <= W; k++) begin : g_sqrt
        logic [W+2:0] rem_sh;
        logic [W+2:0] trial;
        logic [W+2:0] diff;
        t_sq          nxt;

        always_comb begin
            nxt    = r_sq[k-1];
            rem_sh = {r_sq[k-1].rem, r_sq[k-1].x[PW-1 -: 2]};
            trial  = {1'b0, r_sq[k-1].root, 2'b01};
            diff   = rem_sh - trial;
            nxt.x  = r_sq[k-1].x << 2;
            if (rem_sh >= trial) begin
                nxt.rem  = diff[W:0];
                nxt.root = {r_sq[k-1].root[W-2:0], 1'b1};
            end else begin
                nxt.rem  = rem_sh[W:0];
                nxt.root = {r_sq[k-1].root[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqv[k] <= 1'b0;
            end else if (i_en) begin
                r_sqv[k] <= r_sqv[k-1];
            end
            if (i_en) begin
                r_sq[k] <= nxt;
            end
        end
    end

    // Divider setup: round the magnitude, pick the divisor, build numerators.
    t_sq        d_src;
    logic [W:0] m_rnd;
    logic [W:0] m_sat;
    logic [W-1:0] ud;
    logic [W-1:0] ua;
    logic       dsign;
    t_dv        d_nxt;
    t_dv        r_dv  [0:NB];
    logic       r_dvv [0:NB];

    always_comb begin
        d_src     = r_sq[W];
        m_rnd     = {1'b0, d_src.root} + W1'(d_src.rem > {1'b0, d_src.root});
        m_sat     = sat($signed(CW'(m_rnd)));
        d_nxt.op  = d_src.b.op;
        d_nxt.r   = d_src.b.r;
        d_nxt.ovf = d_src.b.ovf;
        d_nxt.dz  = 1'b0;
        ud        = '0;
        dsign     = 1'b0;
        ua        = '0;
        unique case (d_src.b.op)
            v3alu_pkg::OP_NORM: begin
                d_nxt.r[0] = m_sat[W-1:0];
                d_nxt.ovf  = m_sat[W];
            end
            v3alu_pkg::OP_DIV: begin
                ud       = d_src.b.s[W-1] ? W'(-d_src.b.s) : W'(d_src.b.s);
                dsign    = d_src.b.s[W-1];
                d_nxt.dz = (d_src.b.s == '0);
            end
            v3alu_pkg::OP_NORMZ: begin
                ud       = m_rnd[W-1:0];
                d_nxt.dz = (m_rnd == '0);
            end
            default: ;
        endcase
        d_nxt.d = {ud, 1'b0};
        // Numerator is 2*|a|*2^F + |d|, divisor 2*|d|: round half away from zero.
        for (int i = 0; i < 3; i++) begin
            ua             = d_src.b.a[i][W-1] ? W'(-d_src.b.a[i]) : W'(d_src.b.a[i]);
            d_nxt.n[i]     = {ua, {F{1'b0}}, 1'b0} + NB'(ud);
            d_nxt.neg[i]   = d_src.b.a[i][W-1] ^ dsign;
            d_nxt.rem[i]   = '0;
            d_nxt.q[i]     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (i_en) begin
            r_dvv[0] <= r_sqv[W];
        end
        if (i_en) begin
            r_dv[0] <= d_nxt;
        end
    end

    // Restoring division, three lanes, one quotient bit per stage.
    for (genvar j = 1; j <= NB; j++) begin : g_div
        logic [W+1:0] rs   [3];
        logic [W+1:0] diff [3];
        t_dv          nxt;

        always_comb begin
            nxt = r_dv[j-1];
            for (int i = 0; i < 3; i++) begin
                rs[i]     = {r_dv[j-1].rem[i], r_dv[j-1].n[i][NB-1]};
                diff[i]   = rs[i] - {1'b0, r_dv[j-1].d};
                nxt.n[i]  = r_dv[j-1].n[i] << 1;
                if (rs[i] >= {1'b0, r_dv[j-1].d}) begin
                    nxt.rem[i] = diff[i][W:0];
                    nxt.q[i]   = {r_dv[j-1].q[i][NB-2:0], 1'b1};
                end else begin
                    nxt.rem[i] = rs[i][W:0];
                    nxt.q[i]   = {r_dv[j-1].q[i][NB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[j] <= 1'b0;
            end else if (i_en) begin
                r_dvv[j] <= r_dvv[j-1];
            end
            if (i_en) begin
                r_dv[j] <= nxt;
            end
        end
    end

    // Final stage: sign and saturate quotients, select the result.
    t_dv                  f_src;
    logic signed [CW-1:0] qs;
    logic [W:0]           f_sat [3];
    t_val [2:0]           f_r;
    logic                 f_ovf;
    logic                 f_dz;
    logic                 r_ov;
    v3alu_pkg::t_out_word r_out;
    v3alu_pkg::t_out_word f_word;

    always_comb begin
        f_src = r_dv[NB];
        qs    = '0;
        for (int i = 0; i < 3; i++) begin
            qs       = $signed(CW'(f_src.q[i]));
            f_sat[i] = sat(f_src.neg[i] ? -qs : qs);
        end
        f_r   = f_src.r;
        f_ovf = f_src.ovf;
        f_dz  = 1'b0;
        if (f_src.op == v3alu_pkg::OP_DIV || f_src.op == v3alu_pkg::OP_NORMZ) begin
            if (f_src.dz) begin
                f_r   = '0;
                f_ovf = 1'b0;
                f_dz  = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    f_r[i] = f_sat[i][W-1:0];
                end
                f_ovf = f_sat[0][W] | f_sat[1][W] | f_sat[2][W];
            end
        end
        f_word.r_x        = f_r[0];
        f_word.r_y        = f_r[1];
        f_word.r_z        = f_r[2];
        f_word.div_zero   = f_dz;
        f_word.overflowed = f_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dvv[NB];
        end
        if (i_en) begin
            r_out <= f_word;
        end
    end

    assign o_valid = r_ov;
    assign o_word  = r_out;

endmodule

// ----- src/vector3_alu_core.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// input     push / full  (in)         i_in  : v3alu_pkg::t_in_word
// result    empty / pop  (out)        o_out : v3alu_pkg::t_out_word
//
// One word is accepted per cycle while the input queue is not full, and one result
// leaves per cycle while pop is high and the result queue is not empty.
// Q16.16 by default; depth is set by the square root (one bit per stage) and 3-lane divider.
// Reset is synchronous and active low; both queues come up empty.
// When the result queue is full the whole back pipeline holds; the input queue
// keeps taking words until it fills.
module vector3_alu_core #(
    parameter int FRAC_BITS   = v3alu_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = v3alu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  v3alu_pkg::t_in_word   i_in,
    output logic                  empty,
    input  logic                  pop,
    output v3alu_pkg::t_out_word  o_out
);

    logic                 cmd_push;
    v3alu_pkg::t_cmd      cmd_in;
    v3alu_pkg::t_cmd      cmd_out;
    logic                 cmd_empty;
    logic                 out_full;
    logic                 run_en;
    logic                 res_valid;
    v3alu_pkg::t_out_word res_word;

    assign run_en = !out_full;

    v3alu_front u_front (
        .i_push (push),
        .i_full (full),
        .i_word (i_in),
        .o_push (cmd_push),
        .o_cmd  (cmd_in)
    );

    v3alu_fifo #(
        .T     (v3alu_pkg::t_cmd),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (run_en),
        .o_full  (full),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    v3alu_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (run_en),
        .i_valid (!cmd_empty),
        .i_cmd   (cmd_out),
        .o_valid (res_valid),
        .o_word  (res_word)
    );

    v3alu_fifo #(
        .T     (v3alu_pkg::t_out_word),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid && run_en),
        .i_data  (res_word),
        .i_pop   (pop),
        .o_full  (out_full),
        .o_empty (empty),
        .o_data  (o_out)
    );

endmodule

// ----- src/v3alu_check.sv -----
`timescale 1ns / 1ps
module v3alu_check (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input v3alu_pkg::t_out_word  o_out
);

    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A zero divisor gives an all-zero word with no saturation.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out.div_zero |->
            o_out.r_x == '0 && o_out.r_y == '0 && o_out.r_z == '0 && !o_out.overflowed)
        else $error("division by zero word not cleared");

    // Nothing can be queued for output in the cycle after reset without an input.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result appeared right after reset");

    // A waiting result holds until it is popped.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out))
        else $error("waiting result changed");

endmodule

bind vector3_alu_core v3alu_check u_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

// ----- dv/vector3_alu_checker.sv -----
`timescale 1ns / 1ps
module vector3_alu_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  logic                 full,
    input  v3alu_pkg::t_in_word  i_in,
    input  logic                 empty,
    input  logic                 pop,
    input  v3alu_pkg::t_out_word o_out,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int FB = v3alu_pkg::FRAC_BITS_DEF;
    typedef logic signed [127:0] t_wide;

    v3alu_pkg::t_out_word result_queue[$];
    int                   fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = result_queue.size();

    function automatic v3alu_pkg::t_fix saturate(input t_wide v, inout logic ovf);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (v3alu_pkg::DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            ovf = 1'b1;
            return v3alu_pkg::t_fix'(hi);
        end
        if (v < lo) begin
            ovf = 1'b1;
            return v3alu_pkg::t_fix'(lo);
        end
        return v3alu_pkg::t_fix'(v);
    endfunction

    // Nearest, ties toward plus infinity; the shift of a signed value floors.
    function automatic t_wide round_fix(input t_wide v);
        return (v + (t_wide'(1) <<< (FB - 1))) >>> FB;
    endfunction

    // Nearest, ties away from zero.
    function automatic t_wide round_quot(input t_wide n, input t_wide d);
        t_wide un;
        t_wide ud;
        t_wide q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q  = (2 * un + ud) / (2 * ud);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_wide round_sqrt(input t_wide sq);
        t_wide r;
        t_wide t;
        r = 0;
        for (int k = 32; k >= 0; k--) begin
            t = r | (t_wide'(1) <<< k);
            if (t * t <= sq) r = t;
        end
        if (sq - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic v3alu_pkg::t_out_word vector_result(input v3alu_pkg::t_in_word w);
        t_wide                a[3];
        t_wide                b[3];
        t_wide                s;
        t_wide                mag;
        v3alu_pkg::t_fix      r[3];
        logic                 dz;
        logic                 ovf;
        v3alu_pkg::t_out_word res;
        a[0] = w.a_x; a[1] = w.a_y; a[2] = w.a_z;
        b[0] = w.b_x; b[1] = w.b_y; b[2] = w.b_z;
        s    = w.scale_value;
        r    = '{default: '0};
        dz   = 1'b0;
        ovf  = 1'b0;
        case (v3alu_pkg::t_op'(w.op))
            v3alu_pkg::OP_ADD:
                for (int i = 0; i < 3; i++) r[i] = saturate(a[i] + b[i], ovf);
            v3alu_pkg::OP_SUB:
                for (int i = 0; i < 3; i++) r[i] = saturate(a[i] - b[i], ovf);
            v3alu_pkg::OP_NEG:
                for (int i = 0; i < 3; i++) r[i] = saturate(-a[i], ovf);
            v3alu_pkg::OP_SCALE:
                for (int i = 0; i < 3; i++) r[i] = saturate(round_fix(a[i] * s), ovf);
            v3alu_pkg::OP_DIV: begin
                if (s == 0) dz = 1'b1;
                else for (int i = 0; i < 3; i++)
                    r[i] = saturate(round_quot(a[i] <<< FB, s), ovf);
            end
            v3alu_pkg::OP_DOT:
                r[0] = saturate(round_fix(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), ovf);
            v3alu_pkg::OP_CROSS: begin
                r[0] = saturate(round_fix(a[1] * b[2] - a[2] * b[1]), ovf);
                r[1] = saturate(round_fix(a[2] * b[0] - a[0] * b[2]), ovf);
                r[2] = saturate(round_fix(a[0] * b[1] - a[1] * b[0]), ovf);
            end
            v3alu_pkg::OP_NORM, v3alu_pkg::OP_NORMZ: begin
                mag = round_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                if (v3alu_pkg::t_op'(w.op) == v3alu_pkg::OP_NORM) r[0] = saturate(mag, ovf);
                else if (mag == 0) dz = 1'b1;
                else for (int i = 0; i < 3; i++)
                    r[i] = saturate(round_quot(a[i] <<< FB, mag), ovf);
            end
            default: ;
        endcase
        res.r_x        = r[0];
        res.r_y        = r[1];
        res.r_z        = r[2];
        res.div_zero   = dz;
        res.overflowed = ovf;
        return res;
    endfunction

    always @(posedge i_clk) begin
        v3alu_pkg::t_out_word want;
        if (!i_rst_n) begin
            fail_count = 0;
            result_queue.delete();
        end else begin
            if (push && !full) result_queue.push_back(vector_result(i_in));
            if (pop && !empty) begin
                if (result_queue.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    if (o_out.r_x !== want.r_x) begin
                        $error("r_x: expected %0d, got %0d", want.r_x, o_out.r_x);
                        fail_count++;
                    end
                    if (o_out.r_y !== want.r_y) begin
                        $error("r_y: expected %0d, got %0d", want.r_y, o_out.r_y);
                        fail_count++;
                    end
                    if (o_out.r_z !== want.r_z) begin
                        $error("r_z: expected %0d, got %0d", want.r_z, o_out.r_z);
                        fail_count++;
                    end
                    if (o_out.div_zero !== want.div_zero) begin
                        $error("div_zero: expected %0b, got %0b",
                               want.div_zero, o_out.div_zero);
                        fail_count++;
                    end
                    if (o_out.overflowed !== want.overflowed) begin
                        $error("overflowed: expected %0b, got %0b",
                               want.overflowed, o_out.overflowed);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/vector3_alu_core_test.sv -----
`timescale 1ns / 1ps
module vector3_alu_core_test;

    localparam int              RANDOM_WORDS = 800;
    localparam v3alu_pkg::t_fix FIX_MAX = 32'sh7fffffff;
    localparam v3alu_pkg::t_fix FIX_MIN = 32'sh80000000;
    localparam v3alu_pkg::t_fix FIX_ONE = 32'sh00010000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    v3alu_pkg::t_in_word  i_in;
    logic                 empty;
    logic                 pop;
    v3alu_pkg::t_out_word o_out;
    int                   fail_count;
    int                   pending;
    logic                 sending_done;
    int                   pop_cycle;

    v3alu_pkg::t_in_word  directed_words[$];

    vector3_alu_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out)
    );

    vector3_alu_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic v3alu_pkg::t_in_word make_word(
        input v3alu_pkg::t_op op, input v3alu_pkg::t_fix ax, input v3alu_pkg::t_fix ay,
        input v3alu_pkg::t_fix az, input v3alu_pkg::t_fix bx, input v3alu_pkg::t_fix by,
        input v3alu_pkg::t_fix bz, input v3alu_pkg::t_fix s);
        v3alu_pkg::t_in_word w;
        w.op = op; w.a_x = ax; w.a_y = ay; w.a_z = az;
        w.b_x = bx; w.b_y = by; w.b_z = bz; w.scale_value = s;
        return w;
    endfunction

    // Mostly moderate values so the arithmetic lands in range, with some full-width
    // words and some at the ends of the range.
    function automatic v3alu_pkg::t_fix random_fix();
        case ($urandom_range(9))
            0, 1, 2: return v3alu_pkg::t_fix'($urandom);
            3:       return $urandom_range(1) ? FIX_MAX : FIX_MIN;
            4:       return v3alu_pkg::t_fix'($urandom_range(2)) - 1;
            default: return v3alu_pkg::t_fix'($signed($urandom_range(32'h3fffff)) - 32'sh200000);
        endcase
    endfunction

    function automatic v3alu_pkg::t_in_word random_word();
        v3alu_pkg::t_in_word w;
        w.op = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        w.a_x = random_fix(); w.a_y = random_fix(); w.a_z = random_fix();
        w.b_x = random_fix(); w.b_y = random_fix(); w.b_z = random_fix();
        w.scale_value = ($urandom_range(19) == 0) ? '0 : random_fix();
        return w;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(19) == 0) return $urandom_range(60, 15);
        return $urandom_range(3) == 0 ? $urandom_range(3, 1) : 0;
    endfunction

    task automatic send_word(input v3alu_pkg::t_in_word w);
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
    endtask

    initial begin
        push         = 1'b0;
        i_in         = '0;
        i_rst_n      = 1'b0;
        sending_done = 1'b0;
        directed_words = '{
            make_word(v3alu_pkg::OP_ADD, FIX_MAX, FIX_MIN, FIX_ONE, FIX_ONE, -1, 5, 0),
            make_word(v3alu_pkg::OP_ADD, 1, 2, 3, 4, 5, 6, 0),
            make_word(v3alu_pkg::OP_SUB, FIX_MIN, FIX_MAX, 0, FIX_ONE, FIX_MIN, 0, 0),
            make_word(v3alu_pkg::OP_NEG, FIX_MIN, FIX_MAX, 0, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_SCALE, FIX_ONE, 1, -1, 0, 0, 0, 32'sh8000),
            make_word(v3alu_pkg::OP_SCALE, FIX_MAX, FIX_MIN, 3, 0, 0, 0, FIX_MAX),
            make_word(v3alu_pkg::OP_DIV, FIX_ONE, -FIX_ONE, 7, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_DIV, FIX_MAX, FIX_MIN, 3, 0, 0, 0, 2),
            make_word(v3alu_pkg::OP_DIV, 1, -1, 3, 0, 0, 0, 32'sh20000),
            make_word(v3alu_pkg::OP_DOT, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN,
                      FIX_MIN, 0),
            make_word(v3alu_pkg::OP_DOT, FIX_ONE, 1, -1, 32'sh8000, 32'sh8000, 32'sh8000, 0),
            make_word(v3alu_pkg::OP_CROSS, FIX_ONE, 0, 0, 0, FIX_ONE, 0, 0),
            make_word(v3alu_pkg::OP_CROSS, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX,
                      FIX_MIN, 0),
            make_word(v3alu_pkg::OP_NORM, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_NORM, FIX_MIN, FIX_MIN, FIX_MIN, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_NORMZ, 0, 0, 0, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_NORMZ, 1, 0, 0, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_NORMZ, FIX_MIN, FIX_MAX, 1, 0, 0, 0, 0),
            make_word(v3alu_pkg::OP_NONE, FIX_MAX, FIX_MAX, FIX_MAX, 1, 1, 1, 1),
            make_word(v3alu_pkg::t_op'(4'd9), 1, 2, 3, 4, 5, 6, 7)
        };
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed_words[k]) send_word(directed_words[k]);
        for (int k = 0; k < RANDOM_WORDS; k++) send_word(random_word());
        push <= 1'b0;
        sending_done = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, a few random long holds, and one long hold-off that
    // backs the block up into its input.
    initial begin
        int hold_left;
        pop       = 1'b0;
        pop_cycle = 0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            pop_cycle++;
            if (pop_cycle >= 150 && pop_cycle < 450) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (pop_cycle % 512 < 100) begin
                pop <= 1'b1;
            end else if ($urandom_range(149) == 0) begin
                hold_left = $urandom_range(60, 15);
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(24) == 0) ? 1'b0 : ($urandom_range(3) != 0);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
